FILE: design/amrfs_pkg.sv
// shared types and constants of the amr-nb frame stealer
`default_nettype none

package amrfs_pkg;

    localparam int PAYLOAD_BYTES = 19;
    localparam int IDX_W         = 5;
    localparam int MAGIC_LEN     = 6;

    localparam logic [7:0] MAGIC_SEQ [MAGIC_LEN] = '{
        8'h23, 8'h21, 8'h41, 8'h4D, 8'h52, 8'h0A
    };

    localparam logic [3:0] TYPE_740       = 4'd4;
    localparam logic [3:0] TYPE_SID       = 4'd8;
    localparam logic [3:0] TYPE_NODATA    = 4'd15;
    localparam logic [7:0] SID_LAST_BYTE  = 8'h02;
    localparam logic [IDX_W-1:0] SID_ZERO_BYTES = IDX_W'(4);

    localparam logic [7:0] STEAL_PERIOD_RESET = 8'd8;

    // configuration register indexes
    localparam logic [0:0] CFG_STEAL_PERIOD = 1'b0;
    localparam logic [0:0] CFG_REPLACE_MODE = 1'b1;

    typedef enum logic [1:0] {
        PH_MAGIC   = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_HALT    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA      = 2'd0,
        ST_BAD_MAGIC = 2'd1,
        ST_BAD_TYPE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       bad_quality;
        logic       stolen_frame;
    } t_result;

endpackage

`default_nettype wire

FILE: design/amrfs_byte_if.sv
// input byte channel of the frame stealer
`default_nettype none

interface amrfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: design/amrfs_res_if.sv
// result channel of the frame stealer
`default_nettype none

interface amrfs_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       bad_quality;
    logic       stolen_frame;

    modport source (output valid, output out_byte, output status, output bad_quality,
                    output stolen_frame, input ready);
    modport sink   (input valid, input out_byte, input status, input bad_quality,
                    input stolen_frame, output ready);
endinterface

`default_nettype wire

FILE: design/amr_nb_frame_stealer_core.sv
// amr-nb storage-format deframer that replaces one frame in every steal period
//
//   channel     dir  handshake      payload
//   i_byte_ch   in   valid/ready    in_byte
//   o_res_ch    out  valid/ready    out_byte, status, bad_quality, stolen_frame
//   cfg         in   i_cfg_we       i_cfg_index, i_cfg_wdata
//
// one byte a cycle unless the output stalls: each accepted byte is parsed against the
// phase registers and its result lands in the output register on the same edge
// a byte is taken whenever the output register is empty or being drained
// bytes that give no result (halted, dropped payload) are still accepted and dropped
// synchronous active-low reset returns to magic checking with default config
`default_nettype none

module amr_nb_frame_stealer_core
    import amrfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata,
    amrfs_byte_if.sink       i_byte_ch,
    amrfs_res_if.source      o_res_ch
);

    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [7:0]       r_frame_phase, n_frame_phase;
    logic             r_steal_current, n_steal_current;
    logic [7:0]       r_steal_period;
    logic             r_replace_mode;
    logic             r_out_valid;
    t_result          r_res, n_res;
    logic             n_load;

    logic             out_free;
    logic             in_accept;
    logic [7:0]       b;
    logic [3:0]       frame_type;
    logic [3:0]       new_type;
    logic [8:0]       phase_inc;
    logic [IDX_W:0]   idx_inc;

    assign out_free          = !r_out_valid || o_res_ch.ready;
    assign i_byte_ch.ready   = out_free;
    assign in_accept         = i_byte_ch.valid && out_free;
    assign b                 = i_byte_ch.in_byte;
    assign frame_type        = b[6:3];
    assign new_type          = r_replace_mode ? TYPE_NODATA : TYPE_SID;
    assign phase_inc         = {1'b0, r_frame_phase} + 9'd1;
    assign idx_inc           = {1'b0, r_byte_index} + (IDX_W+1)'(1);

    always_comb begin
        n_phase         = r_phase;
        n_byte_index    = r_byte_index;
        n_frame_phase   = r_frame_phase;
        n_steal_current = r_steal_current;
        n_load          = 1'b0;
        n_res           = '{out_byte: b, status: ST_DATA, bad_quality: 1'b0,
                            stolen_frame: 1'b0};
        case (r_phase)
            PH_MAGIC: begin
                n_load = 1'b1;
                if (r_byte_index >= IDX_W'(MAGIC_LEN) ||
                    b != MAGIC_SEQ[r_byte_index[2:0]]) begin
                    n_phase        = PH_HALT;
                    n_res.out_byte = 8'h00;
                    n_res.status   = ST_BAD_MAGIC;
                end else if (r_byte_index == IDX_W'(MAGIC_LEN - 1)) begin
                    n_phase      = PH_HEADER;
                    n_byte_index = '0;
                end else begin
                    n_byte_index = idx_inc[IDX_W-1:0];
                end
            end
            PH_HEADER: begin
                n_load = 1'b1;
                if (frame_type != TYPE_740) begin
                    n_phase        = PH_HALT;
                    n_res.out_byte = 8'h00;
                    n_res.status   = ST_BAD_TYPE;
                end else begin
                    n_steal_current   = (r_frame_phase == 8'd0);
                    // wrap also catches a period lowered mid-stream
                    n_frame_phase     = (phase_inc >= {1'b0, r_steal_period}) ?
                                        8'd0 : phase_inc[7:0];
                    n_phase           = PH_PAYLOAD;
                    n_byte_index      = '0;
                    n_res.bad_quality = !b[2];
                    if (r_frame_phase == 8'd0) begin
                        n_res.out_byte     = {b[7], new_type, 1'b1, b[1:0]};
                        n_res.stolen_frame = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (r_steal_current) begin
                    n_res.stolen_frame = 1'b1;
                    if (!r_replace_mode) begin
                        if (r_byte_index < SID_ZERO_BYTES) begin
                            n_load         = 1'b1;
                            n_res.out_byte = 8'h00;
                        end else if (r_byte_index == SID_ZERO_BYTES) begin
                            n_load         = 1'b1;
                            n_res.out_byte = SID_LAST_BYTE;
                        end
                    end
                end else begin
                    n_load = 1'b1;
                end
                if (idx_inc >= (IDX_W+1)'(PAYLOAD_BYTES)) begin
                    n_phase      = PH_HEADER;
                    n_byte_index = '0;
                end else begin
                    n_byte_index = idx_inc[IDX_W-1:0];
                end
            end
            default: begin
                n_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_MAGIC;
            r_byte_index    <= '0;
            r_frame_phase   <= '0;
            r_steal_current <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase         <= n_phase;
                r_byte_index    <= n_byte_index;
                r_frame_phase   <= n_frame_phase;
                r_steal_current <= n_steal_current;
                r_out_valid     <= n_load;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_load) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steal_period <= STEAL_PERIOD_RESET;
            r_replace_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STEAL_PERIOD: r_steal_period <= i_cfg_wdata;
                CFG_REPLACE_MODE: r_replace_mode <= i_cfg_wdata[0];
                default:          r_replace_mode <= r_replace_mode;
            endcase
        end
    end

    assign o_res_ch.valid        = r_out_valid;
    assign o_res_ch.out_byte     = r_res.out_byte;
    assign o_res_ch.status       = r_res.status;
    assign o_res_ch.bad_quality  = r_res.bad_quality;
    assign o_res_ch.stolen_frame = r_res.stolen_frame;

    // a halted parser never loads a word
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_HALT) |-> !n_load)
        else $error("word loaded while halted");

    // an error word is only ever followed by the halt phase
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status != ST_DATA) |-> r_phase == PH_HALT)
        else $error("error word without halt");

    // bad quality only flags a header, so the parser sits at payload start
    a_quality_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.bad_quality) |->
            (r_phase == PH_PAYLOAD && r_byte_index == '0))
        else $error("bad quality outside header word");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_byte_index < IDX_W'(PAYLOAD_BYTES)))
        else $error("payload index out of range");

    a_magic_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MAGIC) |-> (r_byte_index < IDX_W'(MAGIC_LEN)))
        else $error("magic index out of range");

endmodule

`default_nettype wire

FILE: tb/amr_nb_frame_stealer_core_test.sv
// self-checking testbench of the amr-nb frame stealer core
`timescale 1ns / 1ps

module amr_nb_frame_stealer_core_test
    import amrfs_pkg::*;
();

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 4;
    localparam int STREAM_BYTES = 1800;
    localparam int FRAME_BYTES  = PAYLOAD_BYTES + 1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_wdata;

    amrfs_byte_if byte_ch ();
    amrfs_res_if  res_ch ();

    amr_nb_frame_stealer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_byte_ch   (byte_ch),
        .o_res_ch    (res_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // deframer state as the block should hold it
    t_phase     mdl_phase;
    logic [4:0] mdl_idx;
    logic [7:0] mdl_frame_cnt;
    logic       mdl_steal;
    logic [7:0] mdl_period;
    logic       mdl_mode;

    t_result    exp_words [$];
    logic [7:0] pending_bytes [$];

    int send_gap, send_calm, recv_gap, recv_calm;
    int bytes_queued, bytes_taken, words_checked, stolen_checked, phase_cnt;
    int mismatch_cnt;
    int cycle_cnt;
    int gen_pos;
    t_result got_word, want_word;

    // mostly random waits, with calm stretches where nothing idles
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 18);
        return $urandom_range(0, 2);
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        t_result    r;
        logic       emit;
        logic [8:0] nxt;
        logic [3:0] rtype;
        r.out_byte     = 8'h00;
        r.status       = ST_DATA;
        r.bad_quality  = 1'b0;
        r.stolen_frame = 1'b0;
        emit = 1'b0;
        case (mdl_phase)
            PH_MAGIC: begin
                emit = 1'b1;
                if (mdl_idx >= 5'(MAGIC_LEN) || b != MAGIC_SEQ[mdl_idx[2:0]]) begin
                    r.status  = ST_BAD_MAGIC;
                    mdl_phase = PH_HALT;
                end else begin
                    r.out_byte = b;
                    if (mdl_idx == 5'(MAGIC_LEN - 1)) begin
                        mdl_phase = PH_HEADER;
                        mdl_idx   = '0;
                    end else begin
                        mdl_idx = mdl_idx + 1'b1;
                    end
                end
            end
            PH_HEADER: begin
                emit = 1'b1;
                if (b[6:3] != TYPE_740) begin
                    r.status  = ST_BAD_TYPE;
                    mdl_phase = PH_HALT;
                end else begin
                    mdl_steal     = (mdl_frame_cnt == 8'd0);
                    nxt           = {1'b0, mdl_frame_cnt} + 9'd1;
                    mdl_frame_cnt = (nxt >= {1'b0, mdl_period}) ? 8'd0 : nxt[7:0];
                    mdl_phase     = PH_PAYLOAD;
                    mdl_idx       = '0;
                    r.bad_quality = ~b[2];
                    if (mdl_steal) begin
                        rtype          = mdl_mode ? TYPE_NODATA : TYPE_SID;
                        r.out_byte     = {b[7], rtype, 1'b1, b[1:0]};
                        r.stolen_frame = 1'b1;
                    end else begin
                        r.out_byte = b;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (mdl_steal) begin
                    // sid filler: zero words, then the closing word, rest dropped
                    if (!mdl_mode && mdl_idx <= SID_ZERO_BYTES) begin
                        emit           = 1'b1;
                        r.stolen_frame = 1'b1;
                        r.out_byte     = (mdl_idx == SID_ZERO_BYTES) ? SID_LAST_BYTE : 8'h00;
                    end
                end else begin
                    emit       = 1'b1;
                    r.out_byte = b;
                end
                if (int'(mdl_idx) + 1 >= PAYLOAD_BYTES) begin
                    mdl_phase = PH_HEADER;
                    mdl_idx   = '0;
                end else begin
                    mdl_idx = mdl_idx + 1'b1;
                end
            end
            default: emit = 1'b0;
        endcase
        if (emit)
            exp_words.push_back(r);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_STEAL_PERIOD)
            mdl_period = val;
        else
            mdl_mode = val[0];
    endtask

    task automatic queue_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // well-formed 7.40 kbit/s stream with random header flags and payload
    task automatic queue_stream(input int n);
        logic [7:0] b;
        for (int k = 0; k < n; k++) begin
            if (gen_pos == 0) begin
                b = {1'($urandom), TYPE_740, 3'($urandom)};
            end else begin
                case ($urandom_range(0, 9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
            end
            queue_byte(b);
            gen_pos = (gen_pos + 1) % FRAME_BYTES;
        end
    endtask

    // every queued byte taken by the block and every expected word seen
    task automatic wait_idle();
        while (bytes_taken != bytes_queued || exp_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                predict_byte(byte_ch.in_byte);
                bytes_taken++;
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    byte_ch.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    byte_ch.in_byte <= pending_bytes.pop_front();
                    byte_ch.valid   <= 1'b1;
                    send_gap = draw_wait(send_calm);
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got_word.out_byte     = res_ch.out_byte;
                got_word.status       = t_status'(res_ch.status);
                got_word.bad_quality  = res_ch.bad_quality;
                got_word.stolen_frame = res_ch.stolen_frame;
                if (exp_words.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected word: byte %h status %0d bq %b sf %b",
                                 $realtime, got_word.out_byte, got_word.status,
                                 got_word.bad_quality, got_word.stolen_frame);
                end else begin
                    want_word = exp_words.pop_front();
                    if (got_word !== want_word) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $write("%0t: word %0d: expected byte %h status %0d bq %b sf %b,",
                                   $realtime, words_checked,
                                   want_word.out_byte, want_word.status,
                                   want_word.bad_quality, want_word.stolen_frame);
                            $display(" got byte %h status %0d bq %b sf %b",
                                     got_word.out_byte, got_word.status,
                                     got_word.bad_quality, got_word.stolen_frame);
                        end
                    end
                end
                words_checked++;
                if (got_word.stolen_frame)
                    stolen_checked++;
                recv_gap = draw_wait(recv_calm);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, exp_words.size());
            $display("amr_nb_frame_stealer_core: mismatch");
            $finish;
        end
    end

    initial begin
        logic [3:0] bad_type;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_STEAL_PERIOD;
        cfg_wdata       = 8'h00;
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = 8'h00;
        res_ch.ready    = 1'b0;
        send_gap = 0; send_calm = 0; recv_gap = 0; recv_calm = 0;
        bytes_queued = 0; bytes_taken = 0; words_checked = 0; stolen_checked = 0;
        phase_cnt = 0; mismatch_cnt = 0; cycle_cnt = 0; gen_pos = 0;

        mdl_phase     = PH_MAGIC;
        mdl_idx       = '0;
        mdl_frame_cnt = 8'd0;
        mdl_steal     = 1'b0;
        mdl_period    = STEAL_PERIOD_RESET;
        mdl_mode      = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: magic, then a first frame that gets the sid filler
        for (int k = 0; k < MAGIC_LEN; k++)
            queue_byte(MAGIC_SEQ[k]);
        queue_byte(8'hA7);
        for (int k = 0; k < PAYLOAD_BYTES; k++)
            queue_byte((k % 2 == 0) ? 8'hFF : 8'h00);
        wait_idle();
        phase_cnt++;

        // phases break the stream mid-frame, so mode and period change inside frames
        while (bytes_queued < STREAM_BYTES) begin
            case (phase_cnt)
                1: begin write_reg(CFG_STEAL_PERIOD, 8'd1);   write_reg(CFG_REPLACE_MODE, 8'd1); end
                2: begin write_reg(CFG_STEAL_PERIOD, 8'd255); write_reg(CFG_REPLACE_MODE, 8'd0); end
                3: begin write_reg(CFG_STEAL_PERIOD, 8'd0);   write_reg(CFG_REPLACE_MODE, 8'd0); end
                4: begin write_reg(CFG_STEAL_PERIOD, 8'd2);   write_reg(CFG_REPLACE_MODE, 8'd1); end
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        write_reg(CFG_STEAL_PERIOD, 8'($urandom_range(1, 255)));
                    else
                        write_reg(CFG_STEAL_PERIOD, 8'($urandom_range(1, 6)));
                    write_reg(CFG_REPLACE_MODE, 8'($urandom_range(0, 1)));
                end
            endcase
            queue_stream($urandom_range(10, 90));
            wait_idle();
            phase_cnt++;
        end

        // close the last frame, then an unsupported type halts the parser
        queue_stream((FRAME_BYTES - gen_pos) % FRAME_BYTES);
        bad_type = 4'($urandom_range(0, 14));
        if (bad_type >= TYPE_740)
            bad_type = bad_type + 4'd1;
        queue_byte({1'($urandom), bad_type, 3'($urandom)});
        for (int k = 0; k < 10; k++)
            queue_byte(8'($urandom));
        wait_idle();

        $display("streamed %0d bytes over %0d config phases, ending on a bad frame type",
                 bytes_taken, phase_cnt);
        $display("checked %0d output words, %0d of them from replaced frames",
                 words_checked, stolen_checked);
        if (mismatch_cnt == 0 && exp_words.size() == 0) begin
            $display("amr_nb_frame_stealer_core: match");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("amr_nb_frame_stealer_core: mismatch");
        end
        $finish;
    end

endmodule
